// ===== src/qpt_pkg.sv =====
// Package: widths, constants, payload structs and fixed-point helpers for the pose converter.
`timescale 1ns / 1ps

package qpt_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 15;
  localparam int ATAN_TAB_LEN = 24;
  localparam int CIDX_W       = $clog2(ATAN_TAB_LEN);

  localparam int QW   = 16;            // quaternion component
  localparam int PW   = 24;            // position component
  localparam int PRW  = 32;            // 16x16 products
  localparam int SW   = 34;            // doubled sums of products
  localparam int PSW  = 32;            // saturated sine of pitch, Q.30

  localparam int SQ_STEPS = 31;        // radix-4 digits of a 61-bit radicand
  localparam int SIDX_W   = $clog2(SQ_STEPS);
  localparam int SQ_W     = 62;

  localparam int VW = 36;              // vectoring x/y
  localparam int AW = FRAC_BITS + 4;   // angles
  localparam int RW = FRAC_BITS + 3;   // sin/cos and matrix products
  localparam int MW = RW + 1;          // matrix sums

  localparam int Q30_SH  = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
  localparam int Q30_RND = (FRAC_BITS < 30) ? 29 - FRAC_BITS : 0;
  localparam int Q15_RSH = (FRAC_BITS > 15) ? FRAC_BITS - 15 : 0;
  localparam int Q15_RND = (FRAC_BITS > 15) ? FRAC_BITS - 16 : 0;
  localparam int Q15_LSH = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;

  localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
  localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;

  localparam logic signed [63:0] ATAN_Q30 [ATAN_TAB_LEN] = '{
    64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
    64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
    64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
    64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767,
    64'sd16383,     64'sd8191,      64'sd4095,      64'sd2047,
    64'sd1023,      64'sd511,       64'sd255,       64'sd127
  };

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [AW-1:0] th;
    logic                 neg;
  } rot_t;

  // Q.30 to Q.FRAC_BITS, round half up
  function automatic logic signed [63:0] q30_to_f(input logic signed [63:0] v);
    if (FRAC_BITS >= 30) return v;
    return (v + (64'sd1 <<< Q30_RND)) >>> Q30_SH;
  endfunction

  function automatic logic signed [AW-1:0] atan_f(input logic [CIDX_W-1:0] i);
    logic signed [63:0] t;
    if (32'(i) >= ATAN_TAB_LEN) t = '0;
    else t = q30_to_f(ATAN_Q30[i]);
    return AW'(t);
  endfunction

  function automatic logic signed [RW-1:0] fmul(input logic signed [RW-1:0] a,
                                                input logic signed [RW-1:0] b);
    logic signed [2*RW-1:0] p;
    p = a * b + ($signed((2*RW)'(1)) <<< (FRAC_BITS - 1));
    return RW'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [MW-1:0] v);
    logic signed [MW+15:0] r;
    r = (MW+16)'(v);
    if (FRAC_BITS > 15) r = (r + ($signed((MW+16)'(1)) <<< Q15_RND)) >>> Q15_RSH;
    else if (FRAC_BITS < 15) r = r <<< Q15_LSH;
    if (r > 32'sd32767) return 16'sh7fff;
    if (r < -32'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

endpackage

// ===== src/qpt_if.sv =====
// Interfaces: pose input channel and transform output channel.
`timescale 1ns / 1ps

interface qpt_in_if;
  import qpt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] quat_w;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;
  logic signed [PW-1:0] pos_x;
  logic signed [PW-1:0] pos_y;
  logic signed [PW-1:0] pos_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface qpt_out_if;
  import qpt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   rot_00, rot_01, rot_02;
  logic signed [15:0]   rot_10, rot_11, rot_12;
  logic signed [15:0]   rot_20, rot_21, rot_22;
  logic signed [PW-1:0] trans_x;
  logic signed [PW-1:0] trans_y;
  logic signed [PW-1:0] trans_z;
  modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                  rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, input ready);
  modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, output ready);
endinterface

// ===== src/quaternion_pose_to_transform_top.sv =====
// Top level: quaternion pose to homogeneous transform, one pose per cycle.
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  in_i     | in  | quat_w/x/y/z Q1.15, pos_x/y/z Q8.16       | valid/ready
//  out_o    | out | rot_00..rot_22 Q1.15, trans_x/y/z Q8.16   | valid/ready
//
// Accepts one transaction per cycle while not stalled; a 31-cell square root chain,
// then a CORDIC vectoring chain and a CORDIC rotation chain for each axis.
// The whole chain advances together; it holds while the output register is
// full and not taken, and in_i.ready follows that.
// rst_ni clears only the valid bits; no clearing pass.
`timescale 1ns / 1ps

module quaternion_pose_to_transform_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  qpt_in_if.sink    in_i,
  qpt_out_if.source out_o
);
  import qpt_pkg::*;

  localparam int SQ_END = 3 + SQ_STEPS;
  localparam int LAT    = 10 + SQ_STEPS + 2 * CORDIC_STEPS;
  localparam int AX_ROLL  = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_YAW   = 2;

  typedef struct packed {
    logic signed [SW-1:0]  rn, rd, yn, yd;
    logic signed [PSW-1:0] ps;
  } eul_t;

  typedef struct packed {
    logic signed [PW-1:0] x, y, z;
  } pos_t;

  typedef struct packed {
    logic signed [RW-1:0] cycp, cysp, sysp, sycr, sysr, cycr, cysr, sycp, cpsr, cpcr;
    logic signed [RW-1:0] sp, sr, cr;
  } mat1_t;

  function automatic vec_t vec_pre(input logic signed [VW-1:0] y,
                                   input logic signed [VW-1:0] x);
    vec_t                 v;
    logic signed [AW-1:0] pi_f;
    pi_f   = AW'(q30_to_f(PI_Q30));
    v.zero = (x == 0) && (y == 0);
    v.x    = x;
    v.y    = y;
    v.z    = '0;
    if (x < 0) begin
      v.x = -x;
      v.y = -y;
      v.z = (y >= 0) ? pi_f : -pi_f;
    end
    return v;
  endfunction

  function automatic rot_t rot_pre(input vec_t v);
    rot_t                 r;
    logic signed [AW-1:0] th, pi_f, hp_f;
    pi_f  = AW'(q30_to_f(PI_Q30));
    hp_f  = AW'(q30_to_f(HALF_PI_Q30));
    th    = v.zero ? '0 : v.z;
    r.neg = 1'b0;
    if (th > hp_f) begin
      th    = th - pi_f;
      r.neg = 1'b1;
    end else if (th < -hp_f) begin
      th    = th + pi_f;
      r.neg = 1'b1;
    end
    r.th = th;
    r.x  = RW'(q30_to_f(GAIN_Q30));
    r.y  = '0;
    return r;
  endfunction

  logic             adv;
  logic [LAT-1:0]   vld_q;
  pos_t             pos_q [LAT];

  logic signed [QW-1:0]  w_q, x_q, y_q, z_q;
  logic signed [PRW-1:0] ww_q, xx_q, yy_q, zz_q, wx_q, yz_q, wz_q, xy_q, wy_q, xz_q;
  eul_t                  eul_d, p2_q;
  logic signed [SW-1:0]  ps_raw;
  logic signed [PSW-1:0] ps_mag;
  logic [SQ_W-1:0]       psq_q;
  eul_t                  eul_q [SQ_STEPS+1];
  sq_t                   sq_in;
  sq_t                   sq_o [SQ_STEPS];
  vec_t                  vpre_q [3];
  vec_t                  vc_o [3][CORDIC_STEPS];
  rot_t                  rpre_q [3];
  rot_t                  rc_o [3][CORDIC_STEPS];
  logic signed [RW-1:0]  sin_q [3];
  logic signed [RW-1:0]  cos_q [3];
  mat1_t                 m1_q, m1c_q;
  logic signed [RW-1:0]  t1_q, t2_q, t3_q, t4_q;
  logic signed [15:0]    rot_q [9];
  logic signed [MW-1:0]  m_d [9];

  assign adv        = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // quaternion sums, pitch sine saturated to +-1 in Q.30
  always_comb begin
    eul_d.rn = (SW'(wx_q) + SW'(yz_q)) <<< 1;
    eul_d.rd = SW'(ww_q) - SW'(xx_q) - SW'(yy_q) + SW'(zz_q);
    eul_d.yn = (SW'(wz_q) + SW'(xy_q)) <<< 1;
    eul_d.yd = SW'(ww_q) + SW'(xx_q) - SW'(yy_q) - SW'(zz_q);
    ps_raw   = (SW'(wy_q) - SW'(xz_q)) <<< 1;
    if (ps_raw > (SW'(1) <<< 30)) eul_d.ps = PSW'(1) <<< 30;
    else if (ps_raw < -(SW'(1) <<< 30)) eul_d.ps = -(PSW'(1) <<< 30);
    else eul_d.ps = PSW'(ps_raw);
    ps_mag = (p2_q.ps < 0) ? -p2_q.ps : p2_q.ps;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_q[0] <= '{x: in_i.pos_x, y: in_i.pos_y, z: in_i.pos_z};
      for (int k = 1; k < LAT; k++) pos_q[k] <= pos_q[k-1];
      w_q  <= in_i.quat_w;
      x_q  <= in_i.quat_x;
      y_q  <= in_i.quat_y;
      z_q  <= in_i.quat_z;
      ww_q <= w_q * w_q;
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      zz_q <= z_q * z_q;
      wx_q <= w_q * x_q;
      yz_q <= y_q * z_q;
      wz_q <= w_q * z_q;
      xy_q <= x_q * y_q;
      wy_q <= w_q * y_q;
      xz_q <= x_q * z_q;
      p2_q <= eul_d;
      psq_q <= SQ_W'(ps_mag[30:0]) * SQ_W'(ps_mag[30:0]);
      eul_q[0] <= p2_q;
      for (int k = 1; k <= SQ_STEPS; k++) eul_q[k] <= eul_q[k-1];
    end
  end

  assign sq_in.rem  = (SQ_W'(1) << 60) - psq_q;
  assign sq_in.root = '0;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    qpt_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .idx_i (SIDX_W'(SQ_STEPS - 1 - j)),
      .d_i   ((j == 0) ? sq_in : sq_o[(j == 0) ? 0 : j - 1]),
      .q_o   (sq_o[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vpre_q[AX_ROLL]  <= vec_pre(VW'(eul_q[SQ_STEPS].rn), VW'(eul_q[SQ_STEPS].rd));
      vpre_q[AX_PITCH] <= vec_pre(VW'(eul_q[SQ_STEPS].ps),
                                  VW'($signed({1'b0, sq_o[SQ_STEPS-1].root[31:0]})));
      vpre_q[AX_YAW]   <= vec_pre(VW'(eul_q[SQ_STEPS].yn), VW'(eul_q[SQ_STEPS].yd));
      for (int a = 0; a < 3; a++) begin
        rpre_q[a] <= rot_pre(vc_o[a][CORDIC_STEPS-1]);
        sin_q[a]  <= rc_o[a][CORDIC_STEPS-1].neg ? -rc_o[a][CORDIC_STEPS-1].y
                                                 : rc_o[a][CORDIC_STEPS-1].y;
        cos_q[a]  <= rc_o[a][CORDIC_STEPS-1].neg ? -rc_o[a][CORDIC_STEPS-1].x
                                                 : rc_o[a][CORDIC_STEPS-1].x;
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_step
      qpt_vec_cell u_vec (
        .clk_i (clk_i),
        .en_i  (adv),
        .idx_i (CIDX_W'(j)),
        .d_i   ((j == 0) ? vpre_q[a] : vc_o[a][(j == 0) ? 0 : j - 1]),
        .q_o   (vc_o[a][j])
      );
      qpt_rot_cell u_rot (
        .clk_i (clk_i),
        .en_i  (adv),
        .idx_i (CIDX_W'(j)),
        .d_i   ((j == 0) ? rpre_q[a] : rc_o[a][(j == 0) ? 0 : j - 1]),
        .q_o   (rc_o[a][j])
      );
    end
  end

  // R = Rz(yaw) * Ry(pitch) * Rx(roll)
  always_comb begin
    m_d[0] = MW'(m1c_q.cycp);
    m_d[1] = MW'(t1_q) - MW'(m1c_q.sycr);
    m_d[2] = MW'(t2_q) + MW'(m1c_q.sysr);
    m_d[3] = MW'(m1c_q.sycp);
    m_d[4] = MW'(t3_q) + MW'(m1c_q.cycr);
    m_d[5] = MW'(t4_q) - MW'(m1c_q.cysr);
    m_d[6] = -MW'(m1c_q.sp);
    m_d[7] = MW'(m1c_q.cpsr);
    m_d[8] = MW'(m1c_q.cpcr);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q.cycp <= fmul(cos_q[AX_YAW], cos_q[AX_PITCH]);
      m1_q.cysp <= fmul(cos_q[AX_YAW], sin_q[AX_PITCH]);
      m1_q.sysp <= fmul(sin_q[AX_YAW], sin_q[AX_PITCH]);
      m1_q.sycr <= fmul(sin_q[AX_YAW], cos_q[AX_ROLL]);
      m1_q.sysr <= fmul(sin_q[AX_YAW], sin_q[AX_ROLL]);
      m1_q.cycr <= fmul(cos_q[AX_YAW], cos_q[AX_ROLL]);
      m1_q.cysr <= fmul(cos_q[AX_YAW], sin_q[AX_ROLL]);
      m1_q.sycp <= fmul(sin_q[AX_YAW], cos_q[AX_PITCH]);
      m1_q.cpsr <= fmul(cos_q[AX_PITCH], sin_q[AX_ROLL]);
      m1_q.cpcr <= fmul(cos_q[AX_PITCH], cos_q[AX_ROLL]);
      m1_q.sp   <= sin_q[AX_PITCH];
      m1_q.sr   <= sin_q[AX_ROLL];
      m1_q.cr   <= cos_q[AX_ROLL];
      m1c_q     <= m1_q;
      t1_q      <= fmul(m1_q.cysp, m1_q.sr);
      t2_q      <= fmul(m1_q.cysp, m1_q.cr);
      t3_q      <= fmul(m1_q.sysp, m1_q.sr);
      t4_q      <= fmul(m1_q.sysp, m1_q.cr);
      for (int k = 0; k < 9; k++) rot_q[k] <= to_q15(m_d[k]);
    end
  end

  assign out_o.valid   = vld_q[LAT-1];
  assign out_o.rot_00  = rot_q[0];
  assign out_o.rot_01  = rot_q[1];
  assign out_o.rot_02  = rot_q[2];
  assign out_o.rot_10  = rot_q[3];
  assign out_o.rot_11  = rot_q[4];
  assign out_o.rot_12  = rot_q[5];
  assign out_o.rot_20  = rot_q[6];
  assign out_o.rot_21  = rot_q[7];
  assign out_o.rot_22  = rot_q[8];
  assign out_o.trans_x = pos_q[LAT-1].x;
  assign out_o.trans_y = pos_q[LAT-1].y;
  assign out_o.trans_z = pos_q[LAT-1].z;

`ifndef NO_ASSERTIONS
  a_ps_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (p2_q.ps <= (PSW'(1) <<< 30)) && (p2_q.ps >= -(PSW'(1) <<< 30)))
    else $error("pitch sine outside +-1");

  a_sqrt_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SQ_END] |-> sq_o[SQ_STEPS-1].rem <= (sq_o[SQ_STEPS-1].root << 1))
    else $error("square root remainder too large");

  a_pc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SQ_END] |-> sq_o[SQ_STEPS-1].root <= (SQ_W'(1) << 30))
    else $error("pitch cosine above one");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved while stalled");
`endif
endmodule

// ===== src/qpt_sqrt_cell.sv =====
// One radix-4 digit of the pipelined integer square root.
`timescale 1ns / 1ps

module qpt_sqrt_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [qpt_pkg::SIDX_W-1:0] idx_i,
  input  qpt_pkg::sq_t              d_i,
  output qpt_pkg::sq_t              q_o
);
  import qpt_pkg::*;

  sq_t             cell_d, cell_q;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;

  always_comb begin
    bitv   = SQ_W'(1) << {idx_i, 1'b0};
    trial  = d_i.root + bitv;
    cell_d = d_i;
    if (d_i.rem >= trial) begin
      cell_d.rem  = d_i.rem - trial;
      cell_d.root = (d_i.root >> 1) + bitv;
    end else begin
      cell_d.root = d_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign q_o = cell_q;
endmodule

// ===== src/qpt_vec_cell.sv =====
// One CORDIC vectoring micro-rotation (atan2).
`timescale 1ns / 1ps

module qpt_vec_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [qpt_pkg::CIDX_W-1:0] idx_i,
  input  qpt_pkg::vec_t             d_i,
  output qpt_pkg::vec_t             q_o
);
  import qpt_pkg::*;

  vec_t                 cell_d, cell_q;
  logic signed [VW-1:0] dx, dy;
  logic signed [AW-1:0] at;

  always_comb begin
    dx     = d_i.y >>> idx_i;
    dy     = d_i.x >>> idx_i;
    at     = atan_f(idx_i);
    cell_d = d_i;
    if (d_i.y > 0) begin
      cell_d.x = d_i.x + dx;
      cell_d.y = d_i.y - dy;
      cell_d.z = d_i.z + at;
    end else begin
      cell_d.x = d_i.x - dx;
      cell_d.y = d_i.y + dy;
      cell_d.z = d_i.z - at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign q_o = cell_q;
endmodule

// ===== src/qpt_rot_cell.sv =====
// One CORDIC rotation micro-rotation (sin/cos).
`timescale 1ns / 1ps

module qpt_rot_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [qpt_pkg::CIDX_W-1:0] idx_i,
  input  qpt_pkg::rot_t             d_i,
  output qpt_pkg::rot_t             q_o
);
  import qpt_pkg::*;

  rot_t                 cell_d, cell_q;
  logic signed [RW-1:0] dx, dy;
  logic signed [AW-1:0] at;

  always_comb begin
    dx     = d_i.y >>> idx_i;
    dy     = d_i.x >>> idx_i;
    at     = atan_f(idx_i);
    cell_d = d_i;
    if (d_i.th >= 0) begin
      cell_d.x  = d_i.x - dx;
      cell_d.y  = d_i.y + dy;
      cell_d.th = d_i.th - at;
    end else begin
      cell_d.x  = d_i.x + dx;
      cell_d.y  = d_i.y - dy;
      cell_d.th = d_i.th + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign q_o = cell_q;
endmodule
